@@ design/sphb_pkg.sv @@
// shared constants for the sph boundary repulsive force block
// register indexes, reset values and fixed field widths; no dependencies
package sphb_pkg;

  // fixed point fraction bits default
  localparam int unsigned FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_GRAVITY   = 2'd0;
  localparam logic [1:0] CFG_SMOOTH    = 2'd1;
  localparam logic [1:0] CFG_DEPTH     = 2'd2;
  localparam logic [1:0] CFG_REPULSIVE = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  // reset values of the registers
  localparam logic [30:0] GRAVITY_RST = 31'd642253;
  localparam logic [30:0] SMOOTH_RST  = 31'd65536;
  localparam logic [30:0] DEPTH_RST   = 31'd65536;
  localparam logic        REPULS_RST  = 1'b1;

  // capped intermediates saturate just below 2^62
  localparam logic [61:0] CAP = {62{1'b1}};

endpackage

@@ design/sph_boundary_repulsive_force.sv @@
// sph boundary repulsive force, 2d, one neighbor entry per transaction
// depends on sphb_pkg for register indexes, reset values and the saturation cap
//
// One item is taken at a time. An entry that adds no term (no neighbor, not a
// material/virtual pair, or repulsion off) goes straight to the finish step.
// A neighbor that is processed runs a small sequencer over one shared 32x32
// multiplier (each 64x64 product is 4 passes, between operand load and result
// store) and one restoring divider that retires one quotient bit per cycle
// over a 128-bit dividend. Such an entry stops after the distance check when
// the neighbor lies outside the cutoff; when a term is added, the two
// divisions by squared distance take most of its time. A result waits in an
// output register, so the next entry is accepted while it is still pending.
module sph_boundary_repulsive_force #(
  parameter int unsigned FRAC_BITS = sphb_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [sphb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sphb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input entries
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // self_x, self_y, nbr_x, nbr_y (32 bits each, lowest first)
  input  logic [127:0]                         s_axis_tdata,
  // first_entry, self_material, nbr_present, nbr_virtual (bit 0 up)
  input  logic [3:0]                           s_axis_tuser,
  // last_entry
  input  logic                                 s_axis_tlast,
  // results
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // accel_x, accel_y (32 bits each, lowest first)
  output logic [63:0]                          m_axis_tdata,
  // saturated
  output logic                                 m_axis_tuser
);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_STORE = 4'd4;
  localparam logic [3:0] ST_CHK   = 4'd5;
  localparam logic [3:0] ST_TERM  = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  // operation steps
  localparam logic [3:0] OP_DX2  = 4'd0;
  localparam logic [3:0] OP_DY2  = 4'd1;
  localparam logic [3:0] OP_R0SQ = 4'd2;
  localparam logic [3:0] OP_GD   = 4'd3;
  localparam logic [3:0] OP_Q    = 4'd4;
  localparam logic [3:0] OP_Q2   = 4'd5;
  localparam logic [3:0] OP_Q4   = 4'd6;
  localparam logic [3:0] OP_Q6   = 4'd7;
  localparam logic [3:0] OP_NUM  = 4'd8;
  localparam logic [3:0] OP_F    = 4'd9;
  localparam logic [3:0] OP_MX   = 4'd10;
  localparam logic [3:0] OP_MY   = 4'd11;

  localparam int unsigned SAT_LO = FRAC_BITS + 62;

  // configuration registers
  logic [30:0] gravity_q, smooth_q, depth_q;
  logic        repuls_q;

  // control state
  logic [3:0]  state_q, op_q;
  logic [6:0]  cnt_q;
  logic        last_q, ov_q, ovs_q;
  logic        m_valid_q;

  // payload state
  logic [31:0] ax_q, ay_q;
  logic        sx_q, sy_q, zx_q, zy_q;
  logic [63:0] op_a_q, op_b_q;
  logic [127:0] acc_q, dvd_q;
  logic [63:0] rem_q;
  logic [61:0] quo_q;
  logic        qov_q;
  logic [63:0] dx2_q, dy2_q, r0sq_q, r2_q, dcoef_q;
  logic [61:0] q_q, q2_q, q4_q, diff_q, num_q, f_q, mx_q, my_q;
  logic signed [31:0] sum_x_q, sum_y_q, tx_q, ty_q;
  logic [63:0] m_data_q;
  logic        m_user_q;

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_valid_q && m_axis_tready;

  // a last entry hands its result over once the output register is free
  logic fin_emit;
  assign fin_emit = (state_q == ST_FIN) && last_q && (!m_valid_q || m_axis_tready);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // input decode and position differences
  logic signed [32:0] dx, dy;
  logic               act;
  assign dx  = 33'(signed'(s_axis_tdata[31:0]))  - 33'(signed'(s_axis_tdata[95:64]));
  assign dy  = 33'(signed'(s_axis_tdata[63:32])) - 33'(signed'(s_axis_tdata[127:96]));
  assign act = s_axis_tuser[1] && s_axis_tuser[2] && s_axis_tuser[3] && repuls_q;

  // shared multiplier: one 32x32 partial product per pass
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  pp;
  logic [6:0]   pp_sh;
  logic [127:0] acc_d;
  assign mul_a = cnt_q[0] ? op_a_q[63:32] : op_a_q[31:0];
  assign mul_b = cnt_q[1] ? op_b_q[63:32] : op_b_q[31:0];
  assign pp    = 64'(mul_a) * 64'(mul_b);
  assign pp_sh = {({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]}), 5'b0};
  assign acc_d = acc_q + (128'(pp) << pp_sh);

  // product scaled down by the fraction bits, capped
  logic        msat;
  logic [61:0] mres;
  assign msat = (acc_q[127:SAT_LO] != '0);
  assign mres = msat ? sphb_pkg::CAP : acc_q[SAT_LO-1:FRAC_BITS];

  // shared divider: one quotient bit per cycle
  logic [64:0] rem_sh;
  logic        rem_ge;
  logic [63:0] rem_d;
  logic [61:0] dres;
  assign rem_sh = {rem_q, dvd_q[127]};
  assign rem_ge = (rem_sh >= {1'b0, r2_q});
  assign rem_d  = rem_ge ? 64'(rem_sh - {1'b0, r2_q}) : rem_sh[63:0];
  assign dres   = qov_q ? sphb_pkg::CAP : quo_q;

  // distance check terms
  logic [64:0] r2_sum;
  assign r2_sum = {1'b0, dx2_q} + {1'b0, dy2_q};

  // signed term with saturation
  logic        ovx, ovy, tovf;
  logic [31:0] tx_raw, ty_raw, satx, saty;
  assign ovx    = sx_q ? (mx_q > 62'h80000000) : (mx_q > 62'h7FFFFFFF);
  assign ovy    = sy_q ? (my_q > 62'h80000000) : (my_q > 62'h7FFFFFFF);
  assign tx_raw = sx_q ? (32'd0 - mx_q[31:0]) : mx_q[31:0];
  assign ty_raw = sy_q ? (32'd0 - my_q[31:0]) : my_q[31:0];
  assign satx   = zx_q ? 32'd0 : (sx_q ? 32'h80000000 : 32'h7FFFFFFF);
  assign saty   = zy_q ? 32'd0 : (sy_q ? 32'h80000000 : 32'h7FFFFFFF);
  assign tovf   = ov_q || ovx || ovy;

  // saturating accumulation
  logic signed [32:0] ssx, ssy;
  logic               osx, osy;
  logic [31:0]        nsx, nsy;
  assign ssx = {sum_x_q[31], sum_x_q} + {tx_q[31], tx_q};
  assign ssy = {sum_y_q[31], sum_y_q} + {ty_q[31], ty_q};
  assign osx = ssx[32] != ssx[31];
  assign osy = ssy[32] != ssy[31];
  assign nsx = osx ? (ssx[32] ? 32'h80000000 : 32'h7FFFFFFF) : ssx[31:0];
  assign nsy = osy ? (ssy[32] ? 32'h80000000 : 32'h7FFFFFFF) : ssy[31:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= sphb_pkg::GRAVITY_RST;
      smooth_q  <= sphb_pkg::SMOOTH_RST;
      depth_q   <= sphb_pkg::DEPTH_RST;
      repuls_q  <= sphb_pkg::REPULS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sphb_pkg::CFG_GRAVITY:   gravity_q <= cfg_data_i;
        sphb_pkg::CFG_SMOOTH:    smooth_q  <= cfg_data_i;
        sphb_pkg::CFG_DEPTH:     depth_q   <= cfg_data_i;
        sphb_pkg::CFG_REPULSIVE: repuls_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_DX2;
      cnt_q     <= '0;
      last_q    <= 1'b0;
      ov_q      <= 1'b0;
      ovs_q     <= 1'b0;
      m_valid_q <= 1'b0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
    end else begin
      if (fin_emit) begin
        m_valid_q <= 1'b1;
      end else if (out_acc) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            last_q <= s_axis_tlast;
            ov_q   <= 1'b0;
            op_q   <= OP_DX2;
            if (s_axis_tuser[0]) begin
              sum_x_q <= '0;
              sum_y_q <= 32'sd0 - signed'({1'b0, gravity_q});
              ovs_q   <= 1'b0;
            end
            state_q <= act ? ST_LOAD : ST_FIN;
          end
        end
        ST_LOAD: begin
          cnt_q   <= '0;
          state_q <= (op_q == OP_Q || op_q == OP_F) ? ST_DIV : ST_MUL;
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q[1:0] == 2'd3) begin
            state_q <= ST_STORE;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd127) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          if (op_q == OP_Q || op_q == OP_F) begin
            ov_q <= ov_q | qov_q;
          end else if (op_q != OP_DX2 && op_q != OP_DY2 && op_q != OP_R0SQ
                       && op_q != OP_GD) begin
            ov_q <= ov_q | msat;
          end
          op_q <= op_q + 4'd1;
          if (op_q == OP_GD) begin
            state_q <= ST_CHK;
          end else if (op_q == OP_MY) begin
            state_q <= ST_TERM;
          end else begin
            state_q <= ST_LOAD;
          end
        end
        ST_CHK: begin
          // wrapped distance or outside the cutoff adds nothing
          if (r2_sum[64] || (r2_sum[63:0] >= r0sq_q)) begin
            state_q <= ST_FIN;
          end else if (r2_sum[63:0] == '0) begin
            ovs_q   <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_LOAD;
          end
        end
        ST_TERM: begin
          if (tovf) begin
            ovs_q <= 1'b1;
          end
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          sum_x_q <= nsx;
          sum_y_q <= nsy;
          if (osx || osy) begin
            ovs_q <= 1'b1;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!last_q || fin_emit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sx_q <= dx[32];
          sy_q <= dy[32];
          zx_q <= (dx == '0);
          zy_q <= (dy == '0);
          ax_q <= dx[32] ? 32'(33'sd0 - dx) : dx[31:0];
          ay_q <= dy[32] ? 32'(33'sd0 - dy) : dy[31:0];
        end
      end
      ST_LOAD: begin
        acc_q <= '0;
        rem_q <= '0;
        quo_q <= '0;
        qov_q <= 1'b0;
        case (op_q)
          OP_DX2:  begin op_a_q <= 64'(ax_q);  op_b_q <= 64'(ax_q); end
          OP_DY2:  begin op_a_q <= 64'(ay_q);  op_b_q <= 64'(ay_q); end
          OP_R0SQ: begin
            op_a_q <= 64'({smooth_q, 1'b0});
            op_b_q <= 64'({smooth_q, 1'b0});
          end
          OP_GD:   begin op_a_q <= 64'(gravity_q); op_b_q <= 64'(depth_q); end
          OP_Q:    dvd_q <= 128'(r0sq_q) << FRAC_BITS;
          OP_Q2:   begin op_a_q <= 64'(q_q);   op_b_q <= 64'(q_q); end
          OP_Q4:   begin op_a_q <= 64'(q2_q);  op_b_q <= 64'(q2_q); end
          OP_Q6:   begin op_a_q <= 64'(q4_q);  op_b_q <= 64'(q2_q); end
          OP_NUM:  begin op_a_q <= dcoef_q;    op_b_q <= 64'(diff_q); end
          OP_F:    dvd_q <= 128'(num_q) << (2 * FRAC_BITS);
          OP_MX:   begin op_a_q <= 64'(ax_q);  op_b_q <= 64'(f_q); end
          OP_MY:   begin op_a_q <= 64'(ay_q);  op_b_q <= 64'(f_q); end
          default: ;
        endcase
      end
      ST_MUL: acc_q <= acc_d;
      ST_DIV: begin
        dvd_q <= {dvd_q[126:0], 1'b0};
        rem_q <= rem_d;
        quo_q <= {quo_q[60:0], rem_ge};
        qov_q <= qov_q | quo_q[61];
      end
      ST_STORE: begin
        case (op_q)
          OP_DX2:  dx2_q <= acc_q[63:0];
          OP_DY2:  dy2_q <= acc_q[63:0];
          OP_R0SQ: r0sq_q <= acc_q[63:0];
          OP_GD:   dcoef_q <= (acc_q[63:0] >> FRAC_BITS)
                              + ((acc_q[63:0] >> FRAC_BITS) << 2);
          OP_Q:    q_q <= dres;
          OP_Q2:   q2_q <= mres;
          OP_Q4:   q4_q <= mres;
          OP_Q6:   diff_q <= (mres > q2_q) ? (mres - q2_q) : '0;
          OP_NUM:  num_q <= mres;
          OP_F:    f_q <= dres;
          OP_MX:   mx_q <= mres;
          OP_MY:   my_q <= mres;
          default: ;
        endcase
      end
      ST_CHK: r2_q <= r2_sum[63:0];
      ST_TERM: begin
        tx_q <= tovf ? satx : tx_raw;
        ty_q <= tovf ? saty : ty_raw;
      end
      ST_FIN: begin
        if (fin_emit) begin
          m_data_q <= {sum_y_q, sum_x_q};
          m_user_q <= ovs_q;
        end
      end
      default: ;
    endcase
  end

  // a new result only comes out of the finish step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside finish step");

  // the first division never runs on a zero distance
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && op_q == OP_Q) |-> (r2_q != '0))
    else $error("division by zero distance");

  // the divider always hands over after its last bit
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == 7'd127) |=> (state_q == ST_STORE))
    else $error("divider did not finish");

  // a first entry clears the overflow flag
  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser[0]) |=> !ovs_q)
    else $error("overflow flag kept across first entry");

endmodule

@@ test/sph_boundary_repulsive_force_test.sv @@
// testbench for sph_boundary_repulsive_force: directed and random neighbor streams
// depends on sphb_pkg and the block's rtl; predicts each acceleration result locally
module sph_boundary_repulsive_force_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB = sphb_pkg::FRAC_BITS_DEF;
  localparam logic [63:0] CAP64 = {2'b00, {62{1'b1}}};
  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic        saturated;
  } accel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sphb_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [sphb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [3:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;

  sph_boundary_repulsive_force dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor copy of registers and accumulator
  logic [30:0] gravity_q, smooth_q, depth_q;
  logic repulse_q;
  longint acc_x, acc_y;
  bit acc_ovf;

  accel_t accel_queue[$];
  int mismatch_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  // (a*b)>>FB, capped below 2^62
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, ref bit ov);
    logic [127:0] p;
    p = a * b;
    p = p >> FB;
    if (p > CAP64) begin
      ov = 1;
      return CAP64;
    end
    return p[63:0];
  endfunction

  // floor(n/d), capped below 2^62
  function automatic logic [63:0] div_cap(logic [127:0] n, logic [63:0] d, ref bit ov);
    logic [127:0] q;
    q = n / d;
    if (q > CAP64) begin
      ov = 1;
      return CAP64;
    end
    return q[63:0];
  endfunction

  function automatic longint clamp_term(longint dir, logic [63:0] mag, ref bit ov);
    if (dir >= 0) begin
      if (mag > 64'h7FFFFFFF) begin
        ov = 1;
        return S32MAX;
      end
      return longint'(mag);
    end
    if (mag > 64'h80000000) begin
      ov = 1;
      return S32MIN;
    end
    return -longint'(mag);
  endfunction

  function automatic longint sum_clamp(longint a, longint b);
    longint s;
    s = a + b;
    if (s > S32MAX) begin
      acc_ovf = 1;
      return S32MAX;
    end
    if (s < S32MIN) begin
      acc_ovf = 1;
      return S32MIN;
    end
    return s;
  endfunction

  // lennard-jones style repulsion term for one near virtual neighbor
  function automatic void add_repulsion(longint dx, longint dy);
    logic [63:0] ax, ay, r0, r0sq, dx2, r2, q, q2, q4, q6, diff, dcoef, num, f, mx, my;
    longint tx, ty;
    bit ov;
    ov = 0;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    r0 = 2 * 64'(smooth_q);
    r0sq = r0 * r0;
    dx2 = ax * ax;
    r2 = dx2 + ay * ay;
    // a wrapped squared distance is far away
    if (r2 < dx2 || r2 >= r0sq) return;
    if (r2 == 0) begin
      acc_ovf = 1;
      return;
    end
    q = div_cap({64'd0, r0sq} << FB, r2, ov);
    q2 = mul_shift(q, q, ov);
    q4 = mul_shift(q2, q2, ov);
    q6 = mul_shift(q4, q2, ov);
    diff = q6 > q2 ? q6 - q2 : 0;
    dcoef = ((64'(gravity_q) * 64'(depth_q)) >> FB) * 5;
    num = mul_shift(dcoef, diff, ov);
    f = div_cap({64'd0, num} << (2 * FB), r2, ov);
    mx = mul_shift(ax, f, ov);
    my = mul_shift(ay, f, ov);
    tx = clamp_term(dx, mx, ov);
    ty = clamp_term(dy, my, ov);
    if (ov) begin
      acc_ovf = 1;
      tx = dx > 0 ? S32MAX : (dx < 0 ? S32MIN : 0);
      ty = dy > 0 ? S32MAX : (dy < 0 ? S32MIN : 0);
    end
    acc_x = sum_clamp(acc_x, tx);
    acc_y = sum_clamp(acc_y, ty);
  endfunction

  function automatic void predict_entry(bit first, bit last, bit mat, bit present, bit virt,
                                        logic [31:0] sx, logic [31:0] sy,
                                        logic [31:0] nx, logic [31:0] ny);
    accel_t a;
    if (first) begin
      acc_x = 0;
      acc_y = -longint'(gravity_q);
      acc_ovf = 0;
    end
    if (present && mat && virt && repulse_q)
      add_repulsion(longint'($signed(sx)) - longint'($signed(nx)),
                    longint'($signed(sy)) - longint'($signed(ny)));
    if (last) begin
      a.accel_x = acc_x[31:0];
      a.accel_y = acc_y[31:0];
      a.saturated = acc_ovf;
      accel_queue.push_back(a);
    end
  endfunction

  // one entry transaction; valid stays up until the next idle cycle or a drain
  task automatic send_entry(bit first, bit last, bit mat, bit present, bit virt,
                            logic [31:0] sx, logic [31:0] sy,
                            logic [31:0] nx, logic [31:0] ny);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ny, nx, sy, sx};
    s_axis_tuser <= {virt, present, mat, first};
    s_axis_tlast <= last;
    predict_entry(first, last, mat, present, virt, sx, sy, nx, ny);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (accel_queue.size() != 0) @(posedge clk_i);
    // a non-emitting entry may still be in flight
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sphb_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      sphb_pkg::CFG_GRAVITY: gravity_q = val;
      sphb_pkg::CFG_SMOOTH: smooth_q = val;
      sphb_pkg::CFG_DEPTH: depth_q = val;
      sphb_pkg::CFG_REPULSIVE: repulse_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [30:0] g, logic [30:0] h, logic [30:0] d, bit en);
    wait_drained();
    write_reg(sphb_pkg::CFG_GRAVITY, g);
    write_reg(sphb_pkg::CFG_SMOOTH, h);
    write_reg(sphb_pkg::CFG_DEPTH, d);
    write_reg(sphb_pkg::CFG_REPULSIVE, 31'(en));
    cfg_we_i <= 1'b0;
  endtask

  // random coordinate: mostly near the self position, sometimes anywhere
  function automatic logic [31:0] near_coord(logic [31:0] base, int span);
    if ($urandom_range(9) == 0) return $urandom;
    return base + 32'($signed($urandom_range(2 * span) - span));
  endfunction

  // well-formed particle: first .. last with random neighbors
  task automatic send_particle(int n);
    logic [31:0] sx, sy;
    bit mat;
    sx = $urandom;
    sy = $urandom;
    mat = $urandom_range(7) != 0;
    for (int i = 0; i < n; i++)
      send_entry(i == 0, i == n - 1, mat, $urandom_range(7) != 0, $urandom_range(3) != 0,
                 sx, sy, near_coord(sx, 2 * int'(smooth_q[20:0]) + 1),
                 near_coord(sy, 2 * int'(smooth_q[20:0]) + 1));
  endtask

  // result checker
  always @(posedge clk_i) begin
    accel_t exp_a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (accel_queue.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h %b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_a = accel_queue.pop_front();
        if (m_axis_tdata[31:0] !== exp_a.accel_x || m_axis_tdata[63:32] !== exp_a.accel_y ||
            m_axis_tuser !== exp_a.saturated) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp x=%h y=%h sat=%b got x=%h y=%h sat=%b",
                     exp_a.accel_x, exp_a.accel_y, exp_a.saturated,
                     m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
        end
      end
    end
  end

  // receiver ready, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  task automatic test_directed();
    // lone particle, no neighbor
    send_entry(1, 1, 1, 0, 0, 0, 0, 0, 0);
    // zero distance
    send_entry(1, 1, 1, 1, 1, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    // near along +x, along -y and on the diagonal
    send_entry(1, 0, 1, 1, 1, 32'h10000, 0, 0, 0);
    send_entry(0, 0, 1, 1, 1, 0, 32'hFFFF8000, 0, 0);
    send_entry(0, 1, 1, 1, 1, 32'h8000, 32'h8000, 0, 0);
    // very close: term overflow
    send_entry(1, 1, 1, 1, 1, 1, 32'hFFFFFFFF, 0, 0);
    // extremes of the coordinates, far apart
    send_entry(1, 1, 1, 1, 1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    // not material, not virtual, outside cutoff
    send_entry(1, 0, 0, 1, 1, 32'h4000, 0, 0, 0);
    send_entry(0, 0, 1, 1, 0, 32'h4000, 0, 0, 0);
    send_entry(0, 1, 1, 1, 1, 32'h30000, 0, 0, 0);
    // accumulate without first, then sum saturation
    send_entry(0, 1, 1, 1, 1, 32'h100, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_entry(i == 0, i == 3, 1, 1, 1, 2, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_entry($urandom_range(1), $urandom_range(1), $urandom_range(1), $urandom_range(1),
                   $urandom_range(1), $urandom, $urandom, $urandom, $urandom);
        sent++;
      end else begin
        int n;
        n = $urandom_range(4, 1);
        send_particle(n);
        sent += n;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    test_random(20);
  endtask

  initial begin
    gravity_q = sphb_pkg::GRAVITY_RST;
    smooth_q = sphb_pkg::SMOOTH_RST;
    depth_q = sphb_pkg::DEPTH_RST;
    repulse_q = sphb_pkg::REPULS_RST;
    acc_x = 0;
    acc_y = 0;
    acc_ovf = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 6;
    recv_idle_pct = 47;
    test_directed();
    set_regs(31'h7FFFFFFF, 31'd65536, 31'h7FFFFFFF, 1);
    test_directed();
    set_regs(0, 0, 0, 0);
    test_random(30);
    set_regs(31'd642253, 31'h7FFFFFFF, 31'd65536, 1);
    test_random(30);
    set_regs(31'd642253, 31'd4096, 31'd131072, 1);
    test_random(200);
    send_idle_pct = 47;
    recv_idle_pct = 6;
    test_backpressure();
    test_random(180);
    set_regs(31'd1000, 31'd300, 31'd70000, 1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    wait_drained();
    if (mismatch_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule
